FILE: hw/rtl/tilt_persistence_alarm_defines.svh
// Assertion macros for the tilt persistence alarm
`ifndef TILT_PERSISTENCE_ALARM_DEFINES_SVH
`define TILT_PERSISTENCE_ALARM_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define TPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle
`define TPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tpa_pkg.sv
// Shared types, constants and the arctangent table of the tilt alarm
`default_nettype none

package tpa_pkg;

	localparam int IN_W     = 16;
	localparam int TIME_W   = 32;
	localparam int TILT_W   = 16;
	localparam int ANG_W    = 17;
	localparam int CW       = 28;
	localparam int SUM_W    = 24;
	localparam int ITER_W   = 5;
	localparam int CNT_W    = 7;
	localparam int RECIP_SH = 30;
	localparam int RECIP_W  = 31;
	localparam int LIM_W    = 16;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic signed [ANG_W-1:0] HALF_POS = 17'sd23040;
	localparam logic signed [ANG_W-1:0] HALF_NEG = -17'sd23040;

	localparam logic [LIM_W-1:0]  ANGLE_LIMIT_RST = 16'd2560;
	localparam logic [TIME_W-1:0] DWELL_LIMIT_RST = 32'd5000;

	// Register index taken from paddr[2]
	localparam logic REG_ANGLE_LIMIT = 1'b0;
	localparam logic REG_DWELL_LIMIT = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
		logic post;
		logic div_load;
		logic div_step;
		logic fin;
	} tpa_cmd_t;

	typedef struct packed {
		logic step_last;
		logic cal_done;
	} tpa_sts_t;

	// Rounded 128*atan(2^-i) in degrees
	function automatic logic signed [ANG_W-1:0] atan_step(input logic [ITER_W-1:0] i);
		logic signed [ANG_W-1:0] v;
		case (i)
			5'd0:    v = 17'sd5760;
			5'd1:    v = 17'sd3400;
			5'd2:    v = 17'sd1797;
			5'd3:    v = 17'sd912;
			5'd4:    v = 17'sd458;
			5'd5:    v = 17'sd229;
			5'd6:    v = 17'sd115;
			5'd7:    v = 17'sd57;
			5'd8:    v = 17'sd29;
			5'd9:    v = 17'sd14;
			5'd10:   v = 17'sd7;
			5'd11:   v = 17'sd4;
			5'd12:   v = 17'sd2;
			5'd13:   v = 17'sd1;
			default: v = 17'sd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tpa_regs.sv
// APB configuration registers: angle threshold and dwell limit
`default_nettype none

module tpa_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [tpa_pkg::APB_AW-1:0]  paddr,
	input  wire logic [tpa_pkg::APB_DW-1:0]  pwdata,
	output logic      [tpa_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	output logic      [tpa_pkg::LIM_W-1:0]   angle_limit,
	output logic      [tpa_pkg::TIME_W-1:0]  dwell_limit
);
	import tpa_pkg::*;

	logic [LIM_W-1:0]  angle_limit_q;
	logic [TIME_W-1:0] dwell_limit_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Write the addressed register on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_limit_q <= ANGLE_LIMIT_RST;
			dwell_limit_q <= DWELL_LIMIT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_ANGLE_LIMIT: angle_limit_q <= pwdata[LIM_W-1:0];
				REG_DWELL_LIMIT: dwell_limit_q <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[2])
			REG_ANGLE_LIMIT: prdata = {{(APB_DW-LIM_W){1'b0}}, angle_limit_q};
			REG_DWELL_LIMIT: prdata = dwell_limit_q;
			default:         prdata = '0;
		endcase
	end

	assign angle_limit = angle_limit_q;
	assign dwell_limit = dwell_limit_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tpa_ctrl.sv
// Sequencer: CORDIC steps, calibration divide and result hand-off
`default_nettype none

module tpa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire tpa_pkg::tpa_sts_t sts,
	output tpa_pkg::tpa_cmd_t      cmd
);
	import tpa_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ROT   = 6'b000010,
		S_POST  = 6'b000100,
		S_DIVLD = 6'b001000,
		S_DIV   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ROT;
				end
			end
			S_ROT: begin
				cmd.step = 1'b1;
				if (sts.step_last) state_d = S_POST;
			end
			S_POST: begin
				cmd.post = 1'b1;
				state_d  = sts.cal_done ? S_DIVLD : S_FIN;
			end
			S_DIVLD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result valid until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tpa_dp.sv
// Datapath: iterative CORDIC, calibration sum and divider, lean timer, result register
`default_nettype none

module tpa_dp #(
	parameter int CAL_SAMPLES  = 100,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire tpa_pkg::tpa_cmd_t                  cmd,
	output tpa_pkg::tpa_sts_t                       sts,
	input  wire logic signed [tpa_pkg::IN_W-1:0]    accel_y,
	input  wire logic signed [tpa_pkg::IN_W-1:0]    accel_z,
	input  wire logic        [tpa_pkg::TIME_W-1:0]  now_ms,
	input  wire logic        [tpa_pkg::LIM_W-1:0]   angle_limit,
	input  wire logic        [tpa_pkg::TIME_W-1:0]  dwell_limit,
	output logic signed      [tpa_pkg::TILT_W-1:0]  tilt,
	output logic             [tpa_pkg::TILT_W-1:0]  offset,
	output logic                                    calibrating,
	output logic                                    leaning,
	output logic                                    alarm,
	output logic             [tpa_pkg::TIME_W-1:0]  lean_time_ms
);
	import tpa_pkg::*;

	localparam int PROD_W = SUM_W + RECIP_W;
	// Rounded-up reciprocal of the sample count, exact for sums below 2^23
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
		((64'd1 << RECIP_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

	// Working registers
	logic [ITER_W-1:0]       cnt_q;
	logic signed [CW-1:0]    x_q, y_q;
	logic signed [ANG_W-1:0] ang_q;
	logic                    zero_q;
	logic [TIME_W-1:0]       now_q;
	logic signed [TILT_W-1:0] tilt_q;
	logic [TILT_W-1:0]       offset_q;
	logic                    cal_q;
	logic [TIME_W-1:0]       elapsed_q;
	logic                    div_sign_q, div_pend_q;
	logic [SUM_W-1:0]        mag_q;

	// Architectural state
	logic [CNT_W-1:0]        cal_cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [TILT_W-1:0] ref_q;
	logic                    lean_flag_q;
	logic [TIME_W-1:0]       lean_start_q;

	// Result register
	logic signed [TILT_W-1:0] tilt_r_q;
	logic [TILT_W-1:0]        offset_r_q;
	logic                     cal_r_q, lean_r_q, alarm_r_q;
	logic [TIME_W-1:0]        lean_time_r_q;

	// Combinational helpers
	logic signed [CW-1:0]     z_ext, y_ext, x_sh, y_sh;
	logic signed [ANG_W-1:0]  ang_clamp;
	logic signed [TILT_W-1:0] tilt_c;
	logic signed [ANG_W-1:0]  diff_c, absd_c;
	logic                     cal_item_c;
	logic [PROD_W-1:0]        prod_c;
	logic                     lean_c, alarm_c;
	logic [SUM_W-1:0]         quo_abs;

	assign z_ext = {{(CW-IN_W-8){accel_z[IN_W-1]}}, accel_z, 8'b0};
	assign y_ext = {{(CW-IN_W-8){accel_y[IN_W-1]}}, accel_y, 8'b0};
	assign x_sh  = x_q >>> cnt_q;
	assign y_sh  = y_q >>> cnt_q;

	// Clamp the angle and form the deviation from the reference
	always_comb begin
		if (ang_q > HALF_POS)      ang_clamp = HALF_POS;
		else if (ang_q < HALF_NEG) ang_clamp = HALF_NEG;
		else                       ang_clamp = ang_q;
		tilt_c     = zero_q ? '0 : ang_clamp[TILT_W-1:0];
		diff_c     = {tilt_c[TILT_W-1], tilt_c} - {ref_q[TILT_W-1], ref_q};
		absd_c     = diff_c[ANG_W-1] ? -diff_c : diff_c;
		cal_item_c = cal_cnt_q < CNT_W'(CAL_SAMPLES);
	end

	// Scale the sum magnitude by the reciprocal
	assign prod_c = PROD_W'(mag_q) * PROD_W'(RECIP);

	assign sts.step_last = (cnt_q == ITER_W'(CORDIC_STEPS - 1));
	assign sts.cal_done  = cal_item_c && ((cal_cnt_q + CNT_W'(1)) == CNT_W'(CAL_SAMPLES));

	// Lean decision on the registered deviation
	assign lean_c  = !cal_q && (offset_q > angle_limit);
	assign alarm_c = lean_c && lean_flag_q && (elapsed_q > dwell_limit);
	assign quo_abs = div_sign_q ? -mag_q : mag_q;

	// Step counter for the CORDIC rotation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + ITER_W'(1);
		end
	end

	// Load the vector, then rotate it toward the x axis one step a cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zero_q <= (accel_y == '0) && (accel_z == '0);
			now_q  <= now_ms;
			if (accel_z[IN_W-1]) begin
				x_q   <= -z_ext;
				y_q   <= -y_ext;
				ang_q <= accel_y[IN_W-1] ? HALF_NEG : HALF_POS;
			end else begin
				x_q   <= z_ext;
				y_q   <= y_ext;
				ang_q <= '0;
			end
		end else if (cmd.step) begin
			if (!y_q[CW-1]) begin
				x_q   <= x_q + y_sh;
				y_q   <= y_q - x_sh;
				ang_q <= ang_q + atan_step(cnt_q);
			end else begin
				x_q   <= x_q - y_sh;
				y_q   <= y_q + x_sh;
				ang_q <= ang_q - atan_step(cnt_q);
			end
		end
	end

	// Capture tilt, deviation and elapsed time
	always_ff @(posedge clk) begin
		if (cmd.post) begin
			tilt_q    <= tilt_c;
			offset_q  <= absd_c[TILT_W-1:0];
			cal_q     <= cal_item_c;
			elapsed_q <= now_q - lean_start_q;
		end
	end

	// Divide the calibration sum by the sample count: take the magnitude, then multiply
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			div_sign_q <= sum_q[SUM_W-1];
			mag_q      <= sum_q[SUM_W-1] ? -sum_q : sum_q;
		end else if (cmd.div_step) begin
			mag_q <= prod_c[RECIP_SH +: SUM_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_pend_q <= 1'b0;
		end else if (cmd.div_load) begin
			div_pend_q <= 1'b1;
		end else if (cmd.fin) begin
			div_pend_q <= 1'b0;
		end
	end

	// Accumulate calibration samples; settle the reference and lean timer at hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_cnt_q    <= '0;
			sum_q        <= '0;
			ref_q        <= '0;
			lean_flag_q  <= 1'b0;
			lean_start_q <= '0;
		end else begin
			if (cmd.post && cal_item_c) begin
				sum_q     <= sum_q + {{(SUM_W-TILT_W){tilt_c[TILT_W-1]}}, tilt_c};
				cal_cnt_q <= cal_cnt_q + CNT_W'(1);
			end
			if (cmd.fin) begin
				if (div_pend_q) ref_q <= quo_abs[TILT_W-1:0];
				if (!cal_q) begin
					if (lean_c && !lean_flag_q) begin
						lean_flag_q  <= 1'b1;
						lean_start_q <= now_q;
					end else if (!lean_c) begin
						lean_flag_q <= 1'b0;
					end
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			tilt_r_q      <= tilt_q;
			offset_r_q    <= cal_q ? '0 : offset_q;
			cal_r_q       <= cal_q;
			lean_r_q      <= lean_c;
			alarm_r_q     <= alarm_c;
			lean_time_r_q <= (lean_c && lean_flag_q) ? elapsed_q : '0;
		end
	end

	assign tilt         = tilt_r_q;
	assign offset       = offset_r_q;
	assign calibrating  = cal_r_q;
	assign leaning      = lean_r_q;
	assign alarm        = alarm_r_q;
	assign lean_time_ms = lean_time_r_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tilt_persistence_alarm.sv
// Top level of the accelerometer tilt alarm with dwell timer
//
//   channel  handshake           payload
//   -------  ------------------  ----------------------------------------------
//   in       in_valid/in_ready   accel_y, accel_z, now_ms
//   out      out_valid/out_ready tilt, offset, calibrating, leaning, alarm,
//                                lean_time_ms
//   cfg      APB psel/penable    paddr, pwdata, prdata (0: angle, 4: dwell)
//
// An item passes from acceptance through the one-step-a-cycle CORDIC rotation
// loop and then the post and final steps before the next accept.
// The item that completes calibration also passes a step that takes the
// magnitude of the sum and one that multiplies it by the reciprocal of CAL_SAMPLES.
// A new item is accepted while the previous result waits in the output
// register; a stalled output holds the block at its final step.
// Asynchronous reset clears calibration, reference and lean timer state.
`default_nettype none

`include "tilt_persistence_alarm_defines.svh"

module tilt_persistence_alarm #(
	parameter int CAL_SAMPLES  = 100,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [tpa_pkg::IN_W-1:0]    accel_y,
	input  wire logic signed [tpa_pkg::IN_W-1:0]    accel_z,
	input  wire logic        [tpa_pkg::TIME_W-1:0]  now_ms,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed      [tpa_pkg::TILT_W-1:0]  tilt,
	output logic             [tpa_pkg::TILT_W-1:0]  offset,
	output logic                                    calibrating,
	output logic                                    leaning,
	output logic                                    alarm,
	output logic             [tpa_pkg::TIME_W-1:0]  lean_time_ms,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic        [tpa_pkg::APB_AW-1:0]  paddr,
	input  wire logic        [tpa_pkg::APB_DW-1:0]  pwdata,
	output logic             [tpa_pkg::APB_DW-1:0]  prdata,
	output logic                                    pready
);
	import tpa_pkg::*;

	tpa_cmd_t          cmd;
	tpa_sts_t          sts;
	logic [LIM_W-1:0]  angle_limit;
	logic [TIME_W-1:0] dwell_limit;

	tpa_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.angle_limit (angle_limit),
		.dwell_limit (dwell_limit)
	);

	tpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tpa_dp #(
		.CAL_SAMPLES  (CAL_SAMPLES),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.now_ms       (now_ms),
		.angle_limit  (angle_limit),
		.dwell_limit  (dwell_limit),
		.tilt         (tilt),
		.offset       (offset),
		.calibrating  (calibrating),
		.leaning      (leaning),
		.alarm        (alarm),
		.lean_time_ms (lean_time_ms)
	);

	// Checks
	`TPA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")
	`TPA_ASSERT_NOW(a_cal_quiet, out_valid && calibrating, !leaning && !alarm && offset == '0, "lean signaled during calibration")
	`TPA_ASSERT_NOW(a_alarm_needs_lean, out_valid && alarm, leaning, "alarm without lean")
	`TPA_ASSERT_NOW(a_time_zero_upright, out_valid && !leaning, lean_time_ms == '0, "lean time while upright")

endmodule

`default_nettype wire
